### rtl/tpag_pkg.sv
`timescale 1ns / 1ps

package tpag_pkg;

	localparam int MAX_RANK  = 4;
	localparam int DIM_BITS  = 12;
	localparam int ELEM_BITS = 24;
	localparam int LEN_W     = DIM_BITS + 1;
	localparam int RANK_W    = 3;
	localparam int AX_W      = 2;
	localparam int ORDER_W   = 8;
	localparam int TOT_W     = ELEM_BITS + 1;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = 3;

	typedef logic [AX_W-1:0]      ax_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [DIM_BITS-1:0]  pos_t;
	typedef logic [ELEM_BITS-1:0] elem_t;
	typedef logic [TOT_W-1:0]     tot_t;
	typedef logic [IDX_W-1:0]     idx_t;

	localparam len_t DIM_MAX   = len_t'(1) << DIM_BITS;
	localparam tot_t TOT_LIMIT = tot_t'(1) << ELEM_BITS;
	localparam tot_t TOT_SAT   = TOT_LIMIT + tot_t'(1);

	localparam idx_t REG_RANK       = idx_t'(0);
	localparam idx_t REG_LEN_0      = idx_t'(1);
	localparam idx_t REG_LEN_1      = idx_t'(2);
	localparam idx_t REG_LEN_2      = idx_t'(3);
	localparam idx_t REG_LEN_3      = idx_t'(4);
	localparam idx_t REG_AXIS_ORDER = idx_t'(5);

	localparam rank_t RESET_RANK  = rank_t'(4);
	localparam len_t  RESET_LEN   = len_t'(1);
	localparam logic [ORDER_W-1:0] RESET_ORDER = 8'd228;

	typedef struct packed {
		rank_t                       rank;
		logic [MAX_RANK-1:0][LEN_W-1:0] out_len;
		logic [ORDER_W-1:0]          axis_order;
	} cfg_t;

	typedef enum logic [1:0] {
		SU_IDLE,
		SU_STRIDE,
		SU_SELECT,
		SU_CONTRIB
	} setup_state_t;

	typedef struct packed {
		logic busy;
		logic c_load;
		ax_t  c_idx;
	} setup_ctl_t;

	typedef struct packed {
		elem_t src_offset;
		elem_t dst_index;
		logic  last;
		logic  size_error;
	} out_item_t;

	function automatic rank_t active_rank(cfg_t c);
		rank_t r;
		r = c.rank;
		if (r == rank_t'(0)) begin
			r = rank_t'(1);
		end else if (r > rank_t'(MAX_RANK)) begin
			r = rank_t'(MAX_RANK);
		end
		return r;
	endfunction

	function automatic len_t axis_len(cfg_t c, ax_t j);
		len_t v;
		v = c.out_len[j];
		if (v == len_t'(0)) begin
			v = len_t'(1);
		end else if (v > DIM_MAX) begin
			v = DIM_MAX;
		end
		return v;
	endfunction

	function automatic ax_t axis_src(cfg_t c, ax_t j);
		return c.axis_order[j*AX_W +: AX_W];
	endfunction

endpackage

### rtl/tpag_cfg.sv
`timescale 1ns / 1ps

module tpag_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tpag_pkg::ADDR_W-1:0]  paddr,
	input  logic [tpag_pkg::DATA_W-1:0]  pwdata,
	output logic [tpag_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output tpag_pkg::cfg_t               cfg,
	output logic                         cfg_wr
);

	tpag_pkg::cfg_t cfg_q;
	tpag_pkg::idx_t idx;

	assign idx    = paddr[tpag_pkg::ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rank       <= tpag_pkg::RESET_RANK;
			cfg_q.out_len    <= {tpag_pkg::MAX_RANK{tpag_pkg::RESET_LEN}};
			cfg_q.axis_order <= tpag_pkg::RESET_ORDER;
		end else if (cfg_wr) begin
			unique case (idx)
				tpag_pkg::REG_RANK:       cfg_q.rank <= pwdata[tpag_pkg::RANK_W-1:0];
				tpag_pkg::REG_LEN_0:      cfg_q.out_len[0] <= pwdata[tpag_pkg::LEN_W-1:0];
				tpag_pkg::REG_LEN_1:      cfg_q.out_len[1] <= pwdata[tpag_pkg::LEN_W-1:0];
				tpag_pkg::REG_LEN_2:      cfg_q.out_len[2] <= pwdata[tpag_pkg::LEN_W-1:0];
				tpag_pkg::REG_LEN_3:      cfg_q.out_len[3] <= pwdata[tpag_pkg::LEN_W-1:0];
				tpag_pkg::REG_AXIS_ORDER: cfg_q.axis_order <= pwdata[tpag_pkg::ORDER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			tpag_pkg::REG_RANK:       prdata = tpag_pkg::DATA_W'(cfg_q.rank);
			tpag_pkg::REG_LEN_0:      prdata = tpag_pkg::DATA_W'(cfg_q.out_len[0]);
			tpag_pkg::REG_LEN_1:      prdata = tpag_pkg::DATA_W'(cfg_q.out_len[1]);
			tpag_pkg::REG_LEN_2:      prdata = tpag_pkg::DATA_W'(cfg_q.out_len[2]);
			tpag_pkg::REG_LEN_3:      prdata = tpag_pkg::DATA_W'(cfg_q.out_len[3]);
			tpag_pkg::REG_AXIS_ORDER: prdata = tpag_pkg::DATA_W'(cfg_q.axis_order);
			default:                  prdata = '0;
		endcase
	end

endmodule

### rtl/tpag_setup.sv
`timescale 1ns / 1ps

module tpag_setup (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  tpag_pkg::cfg_t                                     cfg,
	input  logic                                               cfg_wr,
	output tpag_pkg::setup_ctl_t                               ctl,
	output logic [tpag_pkg::MAX_RANK-1:0][tpag_pkg::ELEM_BITS-1:0] stride_sel,
	output logic                                               size_error
);

	tpag_pkg::setup_state_t state_q, state_n;
	tpag_pkg::ax_t          cnt_q, cnt_n;
	tpag_pkg::elem_t        stride_q [tpag_pkg::MAX_RANK];
	logic [tpag_pkg::MAX_RANK-1:0][tpag_pkg::ELEM_BITS-1:0] s_q;
	tpag_pkg::tot_t         tot_q;

	tpag_pkg::rank_t r, r_m1, cnt_r;
	tpag_pkg::ax_t   nxt_idx, sel_src;
	tpag_pkg::len_t  src_len_n, cur_len;
	logic [tpag_pkg::ELEM_BITS+tpag_pkg::LEN_W-1:0] stride_prod;
	logic [tpag_pkg::TOT_W+tpag_pkg::LEN_W-1:0]     tot_prod;
	tpag_pkg::elem_t stride_new, s_new;
	tpag_pkg::tot_t  tot_new;

	// The length of source axis a comes from the lowest output axis that names it.
	function automatic tpag_pkg::len_t src_len(tpag_pkg::cfg_t c, tpag_pkg::ax_t a,
			tpag_pkg::rank_t rk);
		tpag_pkg::len_t v;
		v = tpag_pkg::len_t'(1);
		for (int j = tpag_pkg::MAX_RANK - 1; j >= 0; j--) begin
			if (tpag_pkg::rank_t'(j) < rk &&
					tpag_pkg::axis_src(c, tpag_pkg::ax_t'(j)) == a) begin
				v = tpag_pkg::axis_len(c, tpag_pkg::ax_t'(j));
			end
		end
		return v;
	endfunction

	always_comb begin
		r           = tpag_pkg::active_rank(cfg);
		r_m1        = r - tpag_pkg::rank_t'(1);
		cnt_r       = tpag_pkg::rank_t'(cnt_q);
		nxt_idx     = cnt_q + tpag_pkg::ax_t'(1);
		src_len_n   = src_len(cfg, nxt_idx, r);
		cur_len     = tpag_pkg::axis_len(cfg, cnt_q);
		stride_prod = stride_q[nxt_idx] * src_len_n;
		tot_prod    = tot_q * cur_len;
		sel_src     = tpag_pkg::axis_src(cfg, cnt_q);

		if (cnt_r == r_m1) begin
			stride_new = tpag_pkg::elem_t'(1);
		end else if (cnt_r < r_m1) begin
			stride_new = stride_prod[tpag_pkg::ELEM_BITS-1:0];
		end else begin
			stride_new = '0;
		end

		if (cnt_r >= r) begin
			tot_new = tot_q;
		end else if (tot_prod > {{tpag_pkg::LEN_W{1'b0}}, tpag_pkg::TOT_LIMIT}) begin
			tot_new = tpag_pkg::TOT_SAT;
		end else begin
			tot_new = tot_prod[tpag_pkg::TOT_W-1:0];
		end

		if (cnt_r < r && tpag_pkg::rank_t'(sel_src) < r) begin
			s_new = stride_q[sel_src];
		end else begin
			s_new = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpag_pkg::SU_STRIDE;
			cnt_q   <= tpag_pkg::ax_t'(tpag_pkg::MAX_RANK - 1);
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		ctl     = '0;
		unique case (state_q)
			tpag_pkg::SU_IDLE: begin
			end
			tpag_pkg::SU_STRIDE: begin
				ctl.busy = 1'b1;
				if (cnt_q == '0) begin
					state_n = tpag_pkg::SU_SELECT;
					cnt_n   = tpag_pkg::ax_t'(tpag_pkg::MAX_RANK - 1);
				end else begin
					cnt_n = cnt_q - tpag_pkg::ax_t'(1);
				end
			end
			tpag_pkg::SU_SELECT: begin
				ctl.busy = 1'b1;
				if (cnt_q == '0) begin
					state_n = tpag_pkg::SU_CONTRIB;
					cnt_n   = tpag_pkg::ax_t'(tpag_pkg::MAX_RANK - 1);
				end else begin
					cnt_n = cnt_q - tpag_pkg::ax_t'(1);
				end
			end
			tpag_pkg::SU_CONTRIB: begin
				ctl.busy   = 1'b1;
				ctl.c_load = 1'b1;
				ctl.c_idx  = cnt_q;
				if (cnt_q == '0) begin
					state_n = tpag_pkg::SU_IDLE;
				end else begin
					cnt_n = cnt_q - tpag_pkg::ax_t'(1);
				end
			end
			default: begin
				state_n = tpag_pkg::SU_IDLE;
			end
		endcase
		if (cfg_wr) begin
			state_n = tpag_pkg::SU_STRIDE;
			cnt_n   = tpag_pkg::ax_t'(tpag_pkg::MAX_RANK - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= tpag_pkg::tot_t'(1);
		end else if (cfg_wr) begin
			tot_q <= tpag_pkg::tot_t'(1);
		end else if (state_q == tpag_pkg::SU_STRIDE) begin
			tot_q <= tot_new;
		end
	end

	always_ff @(posedge clk) begin
		if (!cfg_wr && state_q == tpag_pkg::SU_STRIDE) begin
			stride_q[cnt_q] <= stride_new;
		end
		if (!cfg_wr && state_q == tpag_pkg::SU_SELECT) begin
			s_q[cnt_q] <= s_new;
		end
	end

	assign stride_sel = s_q;
	assign size_error = tot_q > tpag_pkg::TOT_LIMIT;

endmodule

### rtl/tpag_walk.sv
`timescale 1ns / 1ps

module tpag_walk (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  tpag_pkg::cfg_t                                     cfg,
	input  tpag_pkg::setup_ctl_t                               ctl,
	input  logic [tpag_pkg::MAX_RANK-1:0][tpag_pkg::ELEM_BITS-1:0] stride_sel,
	input  logic                                               size_error,
	input  logic                                               accept,
	input  logic                                               restart,
	output tpag_pkg::out_item_t                                item
);

	tpag_pkg::pos_t  pos_q [tpag_pkg::MAX_RANK];
	tpag_pkg::elem_t c_q   [tpag_pkg::MAX_RANK];
	tpag_pkg::elem_t dst_q;

	tpag_pkg::pos_t  pos_e [tpag_pkg::MAX_RANK];
	tpag_pkg::elem_t c_e   [tpag_pkg::MAX_RANK];
	tpag_pkg::pos_t  pos_n [tpag_pkg::MAX_RANK];
	tpag_pkg::elem_t c_n   [tpag_pkg::MAX_RANK];
	tpag_pkg::elem_t dst_e, dst_n, offset;
	tpag_pkg::len_t  inc   [tpag_pkg::MAX_RANK];
	logic [tpag_pkg::MAX_RANK-1:0] in_use, done, carry;
	logic            last;
	tpag_pkg::rank_t r;
	logic [tpag_pkg::DIM_BITS+tpag_pkg::ELEM_BITS-1:0] c_prod;

	// Each axis keeps its share of the source offset, so one step is a few adds.
	always_comb begin
		r      = tpag_pkg::active_rank(cfg);
		dst_e  = restart ? '0 : dst_q;
		offset = '0;
		for (int j = 0; j < tpag_pkg::MAX_RANK; j++) begin
			pos_e[j]  = restart ? '0 : pos_q[j];
			c_e[j]    = restart ? '0 : c_q[j];
			in_use[j] = tpag_pkg::rank_t'(j) < r;
			inc[j]    = {1'b0, pos_e[j]} + tpag_pkg::len_t'(1);
			done[j]   = !in_use[j] || inc[j] >= tpag_pkg::axis_len(cfg, tpag_pkg::ax_t'(j));
			offset    = offset + c_e[j];
		end
		last = &done;

		carry[tpag_pkg::MAX_RANK-1] = 1'b1;
		for (int j = tpag_pkg::MAX_RANK - 2; j >= 0; j--) begin
			carry[j] = carry[j+1] & done[j+1];
		end

		for (int j = 0; j < tpag_pkg::MAX_RANK; j++) begin
			pos_n[j] = pos_e[j];
			c_n[j]   = c_e[j];
			if (last) begin
				pos_n[j] = '0;
				c_n[j]   = '0;
			end else if (in_use[j] && carry[j]) begin
				if (done[j]) begin
					pos_n[j] = '0;
					c_n[j]   = '0;
				end else begin
					pos_n[j] = inc[j][tpag_pkg::DIM_BITS-1:0];
					c_n[j]   = c_e[j] + stride_sel[j];
				end
			end
		end
		dst_n = last ? '0 : dst_e + tpag_pkg::elem_t'(1);

		c_prod = pos_q[ctl.c_idx] * stride_sel[ctl.c_idx];

		item.src_offset = offset;
		item.dst_index  = dst_e;
		item.last       = last;
		item.size_error = size_error;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < tpag_pkg::MAX_RANK; j++) begin
				pos_q[j] <= '0;
				c_q[j]   <= '0;
			end
			dst_q <= '0;
		end else if (ctl.c_load) begin
			c_q[ctl.c_idx] <= c_prod[tpag_pkg::ELEM_BITS-1:0];
		end else if (accept) begin
			for (int j = 0; j < tpag_pkg::MAX_RANK; j++) begin
				pos_q[j] <= pos_n[j];
				c_q[j]   <= c_n[j];
			end
			dst_q <= dst_n;
		end
	end

`ifndef SYNTH
	a_no_step_during_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.c_load |-> !accept)
		else $error("request accepted while axis offsets are being rebuilt");

	a_last_clears_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> dst_q == '0 && pos_q[0] == '0 && c_q[0] == '0)
		else $error("walk not back at the first element after the last one");

	a_index_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last |=> dst_q == $past(dst_e) + tpag_pkg::elem_t'(1))
		else $error("output index did not advance by one");
`endif

endmodule

### rtl/tpag_oq.sv
`timescale 1ns / 1ps

module tpag_oq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tpag_pkg::out_item_t push_item,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output tpag_pkg::out_item_t out_item
);

	tpag_pkg::out_item_t mem_q [2];
	logic                wr_q, rd_q;
	logic [1:0]          cnt_q;
	logic                pop;

	assign space     = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

`ifndef SYNTH
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3 && !(cnt_q == 2'd2 && push))
		else $error("output queue overfilled");
`endif

endmodule

### rtl/tensor_permute_address_gen.sv
`timescale 1ns / 1ps

// Address generator for an N-dimensional tensor transpose.
// Each request on the input channel (in_valid/in_ready, field restart) yields one
// result on the output channel (out_valid/out_ready): the source element offset,
// the linear output index, a flag on the final element and a size error flag.
// The walk goes over the output in row-major order, last axis fastest, and
// returns to the first element after the last one or when restart is set.
// A result is registered in the output queue when its request is accepted. One
// request can go in every cycle while no rebuild runs and the receiver keeps up.
// Results wait in a two-entry output queue; when the receiver stalls the queue
// fills and in_ready drops, and nothing is lost.
// Registers are written over the APB port. After reset and after every write,
// the source strides, the per-axis stride selection and the per-axis offsets
// are rebuilt in that order by a short sequence during which in_ready is low.
// Reset clears the walk to the first element and loads the register defaults.

module tensor_permute_address_gen (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tpag_pkg::ADDR_W-1:0]         paddr,
	input  logic [tpag_pkg::DATA_W-1:0]         pwdata,
	output logic [tpag_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tpag_pkg::ELEM_BITS-1:0]      src_offset,
	output logic [tpag_pkg::ELEM_BITS-1:0]      dst_index,
	output logic                                last,
	output logic                                size_error
);

	tpag_pkg::cfg_t       cfg;
	logic                 cfg_wr;
	tpag_pkg::setup_ctl_t ctl;
	logic [tpag_pkg::MAX_RANK-1:0][tpag_pkg::ELEM_BITS-1:0] stride_sel;
	logic                 size_err;
	logic                 space, accept;
	tpag_pkg::out_item_t  item, out_item;

	assign in_ready = !ctl.busy && !cfg_wr && space;
	assign accept   = in_valid & in_ready;

	tpag_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	tpag_setup u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cfg_wr     (cfg_wr),
		.ctl        (ctl),
		.stride_sel (stride_sel),
		.size_error (size_err)
	);

	tpag_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctl        (ctl),
		.stride_sel (stride_sel),
		.size_error (size_err),
		.accept     (accept),
		.restart    (restart),
		.item       (item)
	);

	tpag_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (item),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign src_offset = out_item.src_offset;
	assign dst_index  = out_item.dst_index;
	assign last       = out_item.last;
	assign size_error = out_item.size_error;

`ifndef SYNTH
	a_write_starts_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> ctl.busy && !in_ready)
		else $error("register write did not hold off requests");
`endif

endmodule
